FILE: rtl/cfa_pkg.sv
// cfa_pkg: shared types and fixed widths of the continued fraction approximator
// used by cfa_divider and continued_fraction_approximator; no dependencies
`default_nettype none

package cfa_pkg;

    localparam int VALUE_W   = 64;
    localparam int CONV_W    = 63;
    localparam int TOL_W     = 32;
    localparam int COUNT_W   = 7;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CONV,
        ST_MULA,
        ST_DIFF,
        ST_MULT,
        ST_CHECK,
        ST_OUT
    } cfa_state_t;

    // status of the serial divider, one quotient bit per step
    typedef struct packed {
        logic step;
        logic qbit;
        logic last;
    } cfa_div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/cfa_divider.sv
// cfa_divider: restoring radix-2 divider, one quotient bit per cycle, msb first
// depends on cfa_pkg
`default_nettype none

module cfa_divider #(
    parameter int DIVISOR_W = 33
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [cfa_pkg::VALUE_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0]            divisor,
    output cfa_pkg::cfa_div_stat_t               stat,
    output logic [DIVISOR_W-1:0]                 remainder
);
    import cfa_pkg::*;

    logic                   busy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [VALUE_W-1:0]     p_reg;
    logic [DIVISOR_W-1:0]   q_reg;
    logic [DIVISOR_W-1:0]   r_reg;

    logic [DIVISOR_W:0]     sh;
    logic [DIVISOR_W:0]     sub;
    logic                   ge;
    logic                   last;

    assign sh   = {r_reg, p_reg[VALUE_W-1]};
    assign sub  = sh - {1'b0, q_reg};
    assign ge   = sh >= {1'b0, q_reg};
    assign last = busy_reg && (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        stat.step = busy_reg;
        stat.qbit = ge;
        stat.last = last;
    end

    assign remainder = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= dividend;
            q_reg <= divisor;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            p_reg <= {p_reg[VALUE_W-2:0], 1'b0};
            // remainder stays below the divisor, so the top bit drops safely
            r_reg <= ge ? sub[DIVISOR_W-1:0] : sh[DIVISOR_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/continued_fraction_approximator.sv
// continued_fraction_approximator: top level, fsm, convergent recurrence, tolerance test
// depends on cfa_pkg and cfa_divider
`default_nettype none

// usage
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes relative_tolerance, Q0.32;
//     cfg_ready is always high; write it only while the block is idle
//   input channel (in_valid/in_ready/value_fixed): one signed fixed-point value
//     per transfer, taken only when no item is in work
//   output channel (out_valid/out_ready/...): one fraction per input transfer
// sequence
//   each continued fraction term runs the serial division (the convergent
//     products ride along msb first), a state that closes the recurrence, the
//     shift-add product x*den, the error, the shift-add tolerance product and
//     the compare
//   a term that stops on overflow ends after the division and that closing state
//   the next input is taken the cycle after the result is registered
// reset
//   rst_n clears the fsm and out_valid, and sets the tolerance to 43
// stall
//   a result waits in the output register; the block takes the next item
//     meanwhile and holds its own finished result until out_ready frees the slot
module continued_fraction_approximator #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cfa_pkg::TOL_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [cfa_pkg::VALUE_W-1:0] value_fixed,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [cfa_pkg::VALUE_W-1:0]     numerator_out,
    output logic [cfa_pkg::CONV_W-1:0]             denominator_out,
    output logic                                   overflow_stop,
    output logic [cfa_pkg::COUNT_W-1:0]            term_count
);
    import cfa_pkg::*;

    localparam int QW = FRAC_BITS + 1;          // divisor width, first one is 2^F
    localparam int AW = 2 * VALUE_W - 1;        // x*den
    localparam int RW = AW + TOL_W;             // x*den*tol

    // control state
    cfa_state_t         state_reg, state_next;
    logic [TOL_W-1:0]   tol_reg;
    logic               out_valid_reg;

    // datapath
    logic               neg_reg;
    logic [VALUE_W-1:0] m_reg;
    logic [QW-1:0]      q_reg;
    logic [CONV_W-1:0]  n_reg, pn_reg, dn_reg, pd_reg;
    logic [CONV_W-1:0]  nacc_reg, dacc_reg;
    logic               nst_reg, dst_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CONV_W-1:0]  dsh_reg;
    logic [AW-1:0]      a_reg;
    logic [AW-1:0]      diff_reg;
    logic [TOL_W-1:0]   tsh_reg;
    logic [RW-1:0]      r_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ovf_reg;

    logic [VALUE_W-1:0] out_num_reg;
    logic [CONV_W-1:0]  out_den_reg;
    logic               out_ovf_reg;
    logic [COUNT_W-1:0] out_cnt_reg;

    // divider hookup
    cfa_div_stat_t      div_stat;
    logic [QW-1:0]      div_rem;
    logic [VALUE_W-1:0] div_dividend;
    logic [QW-1:0]      div_divisor;
    logic               div_start;
    logic               out_load;

    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] m_in;
    logic [QW-1:0]      q_one;
    logic [VALUE_W:0]   nh, dh;
    logic [VALUE_W-1:0] nn_sum, nd_sum;
    logic               conv_ovf;
    logic [AW-1:0]      a_add;
    logic [AW-1:0]      b_val;
    logic [RW-1:0]      r_add;
    logic               pass;
    logic               rem_zero;

    // magnitude; the most negative value keeps 2^63 unchanged
    assign raw   = value_fixed;
    assign m_in  = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
    assign q_one = {1'b1, {FRAC_BITS{1'b0}}};

    assign div_dividend = (state_reg == ST_IDLE) ? m_in
                                                 : {{(VALUE_W-QW){1'b0}}, q_reg};
    assign div_divisor  = (state_reg == ST_IDLE) ? q_one : div_rem;

    cfa_divider #(
        .DIVISOR_W (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // horner form of term*n and term*dn as quotient bits arrive msb first;
    // once a partial sum passes 63 bits the sticky flag keeps the overflow
    assign nh = {1'b0, nacc_reg, 1'b0} + (div_stat.qbit ? {2'b00, n_reg}  : {(VALUE_W+1){1'b0}});
    assign dh = {1'b0, dacc_reg, 1'b0} + (div_stat.qbit ? {2'b00, dn_reg} : {(VALUE_W+1){1'b0}});

    assign nn_sum   = {1'b0, nacc_reg} + {1'b0, pn_reg};
    assign nd_sum   = {1'b0, dacc_reg} + {1'b0, pd_reg};
    assign conv_ovf = nst_reg | dst_reg | nn_sum[VALUE_W-1] | nd_sum[VALUE_W-1];

    // x*den, one denominator bit per cycle
    assign a_add = {a_reg[AW-2:0], 1'b0}
                 + (dsh_reg[CONV_W-1] ? {{(AW-VALUE_W){1'b0}}, m_reg} : {AW{1'b0}});

    // num scaled to the fixed-point grid
    assign b_val = {{(AW-CONV_W-FRAC_BITS){1'b0}}, n_reg, {FRAC_BITS{1'b0}}};

    // x*den*tol, one tolerance bit per cycle
    assign r_add = {r_reg[RW-2:0], 1'b0}
                 + (tsh_reg[TOL_W-1] ? {{TOL_W{1'b0}}, a_reg} : {RW{1'b0}});

    assign pass     = {diff_reg, {TOL_W{1'b0}}} <= r_reg;
    assign rem_zero = (div_rem == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_DIV;
            ST_DIV:   if (div_stat.last) state_next = ST_CONV;
            ST_CONV:  state_next = conv_ovf ? ST_OUT : ST_MULA;
            ST_MULA:  if (cnt_reg == CNT_W'(CONV_W - 1)) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MULT;
            ST_MULT:  if (cnt_reg == CNT_W'(TOL_W - 1)) state_next = ST_CHECK;
            ST_CHECK: state_next = (pass || rem_zero) ? ST_OUT : ST_DIV;
            ST_OUT:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = in_valid;
            end
            ST_CHECK: div_start = !(pass || rem_zero);
            ST_OUT:   out_load  = !out_valid_reg || out_ready;
            default:
            begin
                in_ready  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_W'(43);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                tol_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_reg   <= raw[VALUE_W-1];
                    m_reg     <= m_in;
                    q_reg     <= q_one;
                    pn_reg    <= '0;
                    pd_reg    <= CONV_W'(1);
                    n_reg     <= CONV_W'(1);
                    dn_reg    <= '0;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    nacc_reg  <= '0;
                    dacc_reg  <= '0;
                    nst_reg   <= 1'b0;
                    dst_reg   <= 1'b0;
                end
            end
            ST_DIV:
            begin
                if (div_stat.step)
                begin
                    nacc_reg <= nh[CONV_W-1:0];
                    dacc_reg <= dh[CONV_W-1:0];
                    nst_reg  <= nst_reg | nh[VALUE_W] | nh[VALUE_W-1];
                    dst_reg  <= dst_reg | dh[VALUE_W] | dh[VALUE_W-1];
                end
            end
            ST_CONV:
            begin
                if (conv_ovf)
                begin
                    // keep the previous convergent
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    pn_reg    <= n_reg;
                    n_reg     <= nn_sum[CONV_W-1:0];
                    pd_reg    <= dn_reg;
                    dn_reg    <= nd_sum[CONV_W-1:0];
                    count_reg <= count_reg + COUNT_W'(1);
                    dsh_reg   <= nd_sum[CONV_W-1:0];
                    a_reg     <= '0;
                    cnt_reg   <= '0;
                end
            end
            ST_MULA:
            begin
                a_reg   <= a_add;
                dsh_reg <= {dsh_reg[CONV_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_DIFF:
            begin
                diff_reg <= (a_reg >= b_val) ? (a_reg - b_val) : (b_val - a_reg);
                tsh_reg  <= tol_reg;
                r_reg    <= '0;
                cnt_reg  <= '0;
            end
            ST_MULT:
            begin
                r_reg   <= r_add;
                tsh_reg <= {tsh_reg[TOL_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_CHECK:
            begin
                if (div_start)
                begin
                    // next term: p <- q, q <- remainder
                    q_reg    <= div_rem;
                    nacc_reg <= '0;
                    dacc_reg <= '0;
                    nst_reg  <= 1'b0;
                    dst_reg  <= 1'b0;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_num_reg <= neg_reg ? (VALUE_W'(0) - {1'b0, n_reg}) : {1'b0, n_reg};
                    out_den_reg <= dn_reg;
                    out_ovf_reg <= ovf_reg;
                    out_cnt_reg <= count_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign numerator_out   = out_num_reg;
    assign denominator_out = out_den_reg;
    assign overflow_stop   = out_ovf_reg;
    assign term_count      = out_cnt_reg;

    // the divider only steps while the fsm collects quotient bits
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.step |-> (state_reg == ST_DIV))
        else $error("divider stepping outside the division state");

    // a convergent under test always has a nonzero denominator
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF) |-> (dn_reg != '0))
        else $error("zero denominator at error computation");

    // every result uses at least one term
    a_count_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (count_reg != '0))
        else $error("result with no terms");

    // a registered result never has a zero denominator
    a_out_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_den_reg != '0))
        else $error("zero denominator on output");

endmodule

`default_nettype wire

FILE: test/cfa_checker.sv
// cfa_checker: watches the config, input and output channels, predicts each fraction
// depends on cfa_pkg for the port widths
`timescale 1ns / 1ps

module cfa_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [cfa_pkg::TOL_W-1:0]           cfg_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic signed [cfa_pkg::VALUE_W-1:0]  value_fixed,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic signed [cfa_pkg::VALUE_W-1:0]  numerator_out,
    input  wire logic [cfa_pkg::CONV_W-1:0]          denominator_out,
    input  wire logic                                overflow_stop,
    input  wire logic [cfa_pkg::COUNT_W-1:0]         term_count,
    output int                                       fail_count,
    output int                                       pending
);

    localparam int FRAC = 32;
    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] num;
        logic [62:0] den;
        logic        ovf;
        logic [6:0]  cnt;
    } fraction_t;

    fraction_t   fraction_q[$];
    logic [31:0] tol;

    // term*cur + prev within 63 bits
    function automatic logic conv_fits(input logic [63:0] term, input logic [63:0] cur,
                                       input logic [63:0] prev);
        logic [191:0] r;
        r = term * cur + prev;
        return r <= MAX63;
    endfunction

    function automatic fraction_t approximate(input logic [63:0] raw, input logic [31:0] t);
        fraction_t   f;
        logic        neg;
        logic [63:0] m, p, q, pn, pd, n, dn, term, rem, nn, nd;
        logic [255:0] a, b, diff;
        int          count;
        neg = raw[63];
        m = neg ? -raw : raw;
        p = m;
        q = 64'd1 << FRAC;
        pn = 0; pd = 1; n = 1; dn = 0;
        count = 0;
        f.ovf = 1'b0;
        forever
        begin
            term = p / q;
            rem = p % q;
            if (!conv_fits(term, n, pn) || !conv_fits(term, dn, pd))
            begin
                f.ovf = 1'b1;
                break;
            end
            nn = term * n + pn;
            nd = term * dn + pd;
            pn = n; pd = dn; n = nn; dn = nd;
            count++;
            a = 256'(m) * 256'(dn);
            b = 256'(n) << FRAC;
            diff = (a >= b) ? a - b : b - a;
            if ((diff << 32) <= a * 256'(t)) break;
            if (rem == 0) break;
            p = q;
            q = rem;
        end
        f.num = neg ? -n : n;
        f.den = dn[62:0];
        f.cnt = count[6:0];
        return f;
    endfunction

    assign pending = fraction_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        fraction_t e;
        if (!rst_n)
        begin
            tol <= 32'd43;
            fail_count <= 0;
            fraction_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready) tol <= cfg_data;
            if (in_valid && in_ready) fraction_q.push_back(approximate(value_fixed, tol));
            if (out_valid && out_ready)
            begin
                if (fraction_q.size() == 0)
                begin
                    $error("unexpected output transfer num=%0d", numerator_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = fraction_q.pop_front();
                    if (numerator_out !== e.num || denominator_out !== e.den
                        || overflow_stop !== e.ovf || term_count !== e.cnt)
                        fail_count <= fail_count + 1;
                    if (numerator_out !== e.num)
                        $error("numerator_out exp %0d got %0d", $signed(e.num), numerator_out);
                    if (denominator_out !== e.den)
                        $error("denominator_out exp %0d got %0d", e.den, denominator_out);
                    if (overflow_stop !== e.ovf)
                        $error("overflow_stop exp %0d got %0d", e.ovf, overflow_stop);
                    if (term_count !== e.cnt)
                        $error("term_count exp %0d got %0d", e.cnt, term_count);
                end
            end
        end
    end

endmodule

FILE: test/continued_fraction_approximator_tb.sv
// continued_fraction_approximator_tb: stimulus, config phases and verdict
// depends on cfa_pkg, cfa_checker and the block under test
`timescale 1ns / 1ps

module continued_fraction_approximator_tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic signed [63:0] value_fixed;
    logic        out_valid;
    logic        out_ready;
    logic signed [63:0] numerator_out;
    logic [62:0] denominator_out;
    logic        overflow_stop;
    logic [6:0]  term_count;
    int          fail_count;
    int          pending;
    // idling stops near the end; hold_out forces a long receiver stall
    logic        calm;
    logic        hold_out;

    continued_fraction_approximator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .value_fixed(value_fixed),
        .out_valid(out_valid), .out_ready(out_ready),
        .numerator_out(numerator_out), .denominator_out(denominator_out),
        .overflow_stop(overflow_stop), .term_count(term_count)
    );

    cfa_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .value_fixed(value_fixed),
        .out_valid(out_valid), .out_ready(out_ready),
        .numerator_out(numerator_out), .denominator_out(denominator_out),
        .overflow_stop(overflow_stop), .term_count(term_count),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit: ~46 terms per item, 200+ items, several times over
    initial
    begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall bursts, or a long hold-off
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
                out_ready <= 1'b0;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 3);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one input transfer; sender gap before it at random
    task automatic send_value(input logic [63:0] v);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        value_fixed <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // wait for every fraction, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_tol(input logic [31:0] t);
        cfg_valid <= 1'b1;
        cfg_data <= t;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int sel;
        v = {$urandom, $urandom};
        sel = $urandom_range(0, 5);
        // mix of full range and small magnitudes near simple rationals
        case (sel)
            0: v = v;
            1: v = {{32{v[63]}}, v[31:0]};
            2: v = {{44{v[63]}}, v[19:0]};
            3: v = (64'($urandom_range(1, 50)) << 32) / 64'($urandom_range(1, 50));
            4: v = -((64'($urandom_range(1, 99)) << 32) / 64'($urandom_range(1, 99)));
            default: v = {{16{v[63]}}, v[47:0]};
        endcase
        return v;
    endfunction

    initial
    begin
        logic [31:0] tols [6];
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        value_fixed = '0;
        calm = 1'b0;
        hold_out = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero, extremes, exact values, irrational-like values
        send_value(64'd0);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h0000_0001_0000_0000);
        send_value(64'hFFFF_FFFF_0000_0000);
        send_value(64'd1);
        send_value(-64'sd1);
        send_value(64'h0000_0003_243F_6A88);
        send_value(64'h0000_0002_B7E1_5162);
        send_value(64'h0000_0001_6A09_E667);
        send_value(64'h0000_0000_8000_0000);
        send_value(64'hAAAA_AAAA_5555_5555);
        drain();
        // extremes of the tolerance: exact and fully loose
        write_tol(32'd0);
        send_value(64'h0000_0003_243F_6A88);
        send_value(64'h0000_0000_0000_0003);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'h8000_0000_0000_0001);
        drain();
        write_tol(32'hFFFF_FFFF);
        send_value(64'h0000_0003_243F_6A88);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h0000_0000_0000_0001);
        drain();

        tols = '{32'd43, 32'd0, 32'd1, 32'h0001_0000, 32'hFFFF_FFFF, 32'd43};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_tol(ph == 5 ? tols[ph] : (ph == 3 ? $urandom : tols[ph]));
            if (ph == 1)
            begin
                // long receiver stall while the sender keeps offering;
                // long enough for two slow items to finish and block the input
                hold_out <= 1'b1;
                fork
                    begin
                        repeat (40000) @(negedge clk);
                        hold_out <= 1'b0;
                    end
                join_none
            end
            if (ph == 5) calm = 1'b1;
            for (int i = 0; i < 33; i++)
                send_value(random_value());
            // sender pauses until every fraction is back
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cfa_pkg.sv
rtl/cfa_divider.sv
rtl/continued_fraction_approximator.sv
test/cfa_checker.sv
test/continued_fraction_approximator_tb.sv
